// File: rtl/cir_pkg.sv
package cir_pkg;

  // body table geometry
  localparam int BODY_COUNT = 64;
  localparam int ADDR_W     = $clog2(BODY_COUNT);

  // restoring division: one quotient bit per cycle
  localparam int NUM_W     = 53;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // multiplier steps
  localparam int DOT_LAST  = 3;
  localparam int KMUL_LAST = 4;
  localparam int DMUL_LAST = 6;

  // function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_CONTACT = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  // one table entry
  typedef struct packed {
    logic              dynamic;
    logic [23:0]       inv_mass;
    logic signed [31:0] vel_z;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
  } body_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_WR,
    OP_RD_A,
    OP_RD_B,
    OP_LATCH_B,
    OP_DOT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_KMUL,
    OP_DMUL,
    OP_WR_A,
    OP_WR_B,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       dot_neg;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_A,
    ST_RD_B,
    ST_LATCH_B,
    ST_DOT,
    ST_CHECK,
    ST_DIV,
    ST_KMUL,
    ST_DMUL,
    ST_WR_A,
    ST_WR_B,
    ST_RESULT
  } ctrl_state_e;

endpackage

// File: rtl/collision_impulse_resolver.sv
// Collision impulse resolver: a table of 64 rigid bodies and a contact solver.
// Command channel: an item transfer happens at a rising edge with start high and
// busy low. func 0 loads a body, func 1 resolves a contact between two bodies,
// func 2 reads a body back; any other code gives an all-zero result.
// Result channel: each item gives one result, shown for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must take it in that cycle.
// Steps between the transfer and done_o: a load writes its entry; a read
//   reads the table; an unknown code goes straight to the result; a contact
//   reads both bodies and forms the dot product, and only when they approach
//   divides, scales the impulse, updates the velocities and writes them back.
// A new command may be given in the cycle that done_o shows. The contact time
// is set by the restoring divider (one quotient bit per cycle) and the single
// shared multiplier, used for the dot product, the impulse scaling and the six updates.
// Reset clears the controller and the result strobe; the body table keeps its
// contents and is undefined until each entry is loaded.
module collision_impulse_resolver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [5:0]         first_index_i,
  input  logic [5:0]         second_index_i,
  input  logic signed [31:0] load_vel_x_i,
  input  logic signed [31:0] load_vel_y_i,
  input  logic signed [31:0] load_vel_z_i,
  input  logic [23:0]        load_inv_mass_i,
  input  logic               load_dynamic_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic               done_o,
  output logic               applied_o,
  output logic signed [31:0] first_vel_x_o,
  output logic signed [31:0] first_vel_y_o,
  output logic signed [31:0] first_vel_z_o,
  output logic signed [31:0] second_vel_x_o,
  output logic signed [31:0] second_vel_y_o,
  output logic signed [31:0] second_vel_z_o
);
  import cir_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  cir_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (func_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // body table and arithmetic
  cir_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .first_index_i   (first_index_i),
    .second_index_i  (second_index_i),
    .load_vel_x_i    (load_vel_x_i),
    .load_vel_y_i    (load_vel_y_i),
    .load_vel_z_i    (load_vel_z_i),
    .load_inv_mass_i (load_inv_mass_i),
    .load_dynamic_i  (load_dynamic_i),
    .normal_x_i      (normal_x_i),
    .normal_y_i      (normal_y_i),
    .normal_z_i      (normal_z_i),
    .done_o          (done_o),
    .applied_o       (applied_o),
    .first_vel_x_o   (first_vel_x_o),
    .first_vel_y_o   (first_vel_y_o),
    .first_vel_z_o   (first_vel_z_o),
    .second_vel_x_o  (second_vel_x_o),
    .second_vel_y_o  (second_vel_y_o),
    .second_vel_z_o  (second_vel_z_o)
  );

endmodule

// File: rtl/cir_ctrl.sv
module cir_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          func_i,
  input  cir_pkg::dp_status_t status_i,
  output cir_pkg::dp_cmd_t    cmd_o,
  output logic                busy
);
  import cir_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d   = state_q;
    cnt_d     = '0;
    cmd_o.op  = OP_NONE;
    cmd_o.idx = cnt_q;
    busy      = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = OP_CAPTURE;
          priority if (func_i == FUNC_LOAD) state_d = ST_LOAD;
          else if (func_i == FUNC_CONTACT || func_i == FUNC_READ) state_d = ST_RD_A;
          else state_d = ST_RESULT;
        end
      end
      ST_LOAD: begin
        cmd_o.op = OP_LOAD_WR;
        state_d  = ST_RESULT;
      end
      ST_RD_A: begin
        cmd_o.op = OP_RD_A;
        state_d  = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.op = OP_RD_B;
        state_d  = (status_i.func == FUNC_CONTACT) ? ST_LATCH_B : ST_RESULT;
      end
      ST_LATCH_B: begin
        cmd_o.op = OP_LATCH_B;
        state_d  = ST_DOT;
      end
      ST_DOT: begin
        cmd_o.op = OP_DOT;
        if (cnt_q == CNT_W'(DOT_LAST)) state_d = ST_CHECK;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_CHECK: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = status_i.dot_neg ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_KMUL;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_KMUL: begin
        cmd_o.op = OP_KMUL;
        if (cnt_q == CNT_W'(KMUL_LAST)) state_d = ST_DMUL;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_DMUL: begin
        cmd_o.op = OP_DMUL;
        if (cnt_q == CNT_W'(DMUL_LAST)) state_d = ST_WR_A;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_WR_A: begin
        cmd_o.op = OP_WR_A;
        state_d  = ST_WR_B;
      end
      ST_WR_B: begin
        cmd_o.op = OP_WR_B;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        cmd_o.op = OP_RESULT;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/cir_datapath.sv
module cir_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cir_pkg::dp_cmd_t    cmd_i,
  output cir_pkg::dp_status_t status_o,
  input  logic [1:0]          func_i,
  input  logic [5:0]          first_index_i,
  input  logic [5:0]          second_index_i,
  input  logic signed [31:0]  load_vel_x_i,
  input  logic signed [31:0]  load_vel_y_i,
  input  logic signed [31:0]  load_vel_z_i,
  input  logic [23:0]         load_inv_mass_i,
  input  logic                load_dynamic_i,
  input  logic signed [15:0]  normal_x_i,
  input  logic signed [15:0]  normal_y_i,
  input  logic signed [15:0]  normal_z_i,
  output logic                done_o,
  output logic                applied_o,
  output logic signed [31:0]  first_vel_x_o,
  output logic signed [31:0]  first_vel_y_o,
  output logic signed [31:0]  first_vel_z_o,
  output logic signed [31:0]  second_vel_x_o,
  output logic signed [31:0]  second_vel_y_o,
  output logic signed [31:0]  second_vel_z_o
);
  import cir_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -41'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // body table
  body_t mem [BODY_COUNT];
  body_t rd_q;

  // captured item
  logic [1:0]         func_q;
  logic [ADDR_W-1:0]  a_q, b_q;
  logic signed [15:0] n_q [3];
  body_t              load_q;

  // working registers
  logic signed [31:0] va_q [3];
  logic signed [31:0] vb_q [3];
  logic [23:0]        inva_q, invb_q;
  logic               dyna_q, dynb_q;
  logic signed [64:0] prod_q;
  logic signed [50:0] dot_q;
  logic [NUM_W-1:0]   num_q, quo_q;
  logic [25:0]        rem_q, den_q;
  logic [53:0]        acc_q;
  logic [37:0]        ka_q, kb_q;
  logic               applied_q;

  // result registers
  logic               done_q;
  logic signed [31:0] fv_q [3];
  logic signed [31:0] sv_q [3];

  logic [24:0]        ia_eff, ib_eff;
  logic signed [32:0] rel [3];
  logic signed [38:0] ma;
  logic signed [25:0] mb;
  logic [26:0]        rem_sh;
  logic               qbit;
  logic [53:0]        ksum;
  logic signed [50:0] neg_dot;
  logic signed [39:0] delta;
  logic [1:0]         dax;

  assign status_o.func    = func_q;
  assign status_o.dot_neg = dot_q[50];

  // zero inverse mass stands for one
  assign ia_eff = (inva_q == '0) ? 25'h10000 : {1'b0, inva_q};
  assign ib_eff = (invb_q == '0) ? 25'h10000 : {1'b0, invb_q};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rel[i] = {vb_q[i][31], vb_q[i]} - {va_q[i][31], va_q[i]};
    end
  end

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      OP_DOT: begin
        if (cmd_i.idx < CNT_W'(3)) begin
          ma = 39'(rel[cmd_i.idx[1:0]]);
          mb = 26'(n_q[cmd_i.idx[1:0]]);
        end
      end
      OP_KMUL: begin
        ma = cmd_i.idx[0] ? {13'b0, quo_q[52:27]} : {12'b0, quo_q[26:0]};
        mb = cmd_i.idx[1] ? {1'b0, ib_eff} : {1'b0, ia_eff};
      end
      OP_DMUL: begin
        if (cmd_i.idx < CNT_W'(3)) begin
          ma = {1'b0, ka_q};
          mb = 26'(n_q[cmd_i.idx[1:0]]);
        end else if (cmd_i.idx < CNT_W'(6)) begin
          ma = {1'b0, kb_q};
          mb = 26'(n_q[2'(cmd_i.idx - CNT_W'(3))]);
        end
      end
      default: ;
    endcase
  end

  // division step and helpers
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign ksum    = acc_q + {prod_q[26:0], 27'b0};
  assign neg_dot = -dot_q;
  assign delta   = prod_q[53:14];
  assign dax     = 2'(cmd_i.idx - CNT_W'(1));

  // table read and write
  always_ff @(posedge clk_i) begin
    rd_q <= mem[(cmd_i.op == OP_RD_B) ? b_q : a_q];
    unique case (cmd_i.op)
      OP_LOAD_WR: mem[a_q] <= load_q;
      OP_WR_A:    mem[a_q] <= {dyna_q, inva_q, va_q[2], va_q[1], va_q[0]};
      OP_WR_B:    mem[b_q] <= {dynb_q, invb_q, vb_q[2], vb_q[1], vb_q[0]};
      default: ;
    endcase
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        func_q    <= func_i;
        a_q       <= first_index_i[ADDR_W-1:0];
        b_q       <= second_index_i[ADDR_W-1:0];
        n_q[0]    <= normal_x_i;
        n_q[1]    <= normal_y_i;
        n_q[2]    <= normal_z_i;
        load_q    <= {load_dynamic_i, load_inv_mass_i, load_vel_z_i, load_vel_y_i,
                      load_vel_x_i};
        applied_q <= 1'b0;
      end
      OP_LOAD_WR: begin
        va_q[0] <= load_q.vel_x;
        va_q[1] <= load_q.vel_y;
        va_q[2] <= load_q.vel_z;
      end
      OP_RD_B: begin
        va_q[0] <= rd_q.vel_x;
        va_q[1] <= rd_q.vel_y;
        va_q[2] <= rd_q.vel_z;
        inva_q  <= rd_q.inv_mass;
        dyna_q  <= rd_q.dynamic;
      end
      OP_LATCH_B: begin
        vb_q[0] <= rd_q.vel_x;
        vb_q[1] <= rd_q.vel_y;
        vb_q[2] <= rd_q.vel_z;
        invb_q  <= rd_q.inv_mass;
        dynb_q  <= rd_q.dynamic;
      end
      OP_DOT: begin
        if (cmd_i.idx == '0) dot_q <= '0;
        else dot_q <= dot_q + prod_q[50:0];
      end
      OP_DIV_INIT: begin
        num_q     <= {neg_dot[49:0], 3'b000};
        rem_q     <= '0;
        quo_q     <= '0;
        den_q     <= 26'(ia_eff) + 26'(ib_eff);
        applied_q <= dot_q[50];
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        quo_q <= {quo_q[NUM_W-2:0], qbit};
        rem_q <= qbit ? 26'(rem_sh - {1'b0, den_q}) : rem_sh[25:0];
      end
      OP_KMUL: begin
        unique case (cmd_i.idx)
          CNT_W'(1), CNT_W'(3): acc_q <= prod_q[53:0];
          CNT_W'(2):            ka_q  <= ksum[53:16];
          CNT_W'(4):            kb_q  <= ksum[53:16];
          default: ;
        endcase
      end
      OP_DMUL: begin
        if (cmd_i.idx >= CNT_W'(1) && cmd_i.idx <= CNT_W'(3)) begin
          if (dyna_q) va_q[dax] <= sat32(41'(va_q[dax]) - 41'(delta));
        end else if (cmd_i.idx >= CNT_W'(4)) begin
          if (dynb_q) vb_q[2'(cmd_i.idx - CNT_W'(4))] <=
            sat32(41'(vb_q[2'(cmd_i.idx - CNT_W'(4))]) + 41'(delta));
        end
      end
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT) begin
      applied_o <= (func_q == FUNC_CONTACT) && applied_q;
      for (int i = 0; i < 3; i++) begin
        fv_q[i] <= (func_q == FUNC_LOAD || func_q == FUNC_CONTACT || func_q == FUNC_READ)
                   ? va_q[i] : '0;
        sv_q[i] <= (func_q == FUNC_CONTACT) ? vb_q[i] : '0;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (cmd_i.op == OP_RESULT);
  end

  assign done_o         = done_q;
  assign first_vel_x_o  = fv_q[0];
  assign first_vel_y_o  = fv_q[1];
  assign first_vel_z_o  = fv_q[2];
  assign second_vel_x_o = sv_q[0];
  assign second_vel_y_o = sv_q[1];
  assign second_vel_z_o = sv_q[2];

endmodule

// File: rtl/cir_checker.sv
module cir_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // an accepted command occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("busy not raised after command transfer");

  // each result is a single-cycle strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // the block is free again while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("busy while result shown");

  // finishing an item always delivers its result
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

endmodule

bind collision_impulse_resolver cir_checker u_cir_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

// File: verif/cir_checker.sv
module tb_cir_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         func_i,
  input  logic [5:0]         first_index_i,
  input  logic [5:0]         second_index_i,
  input  logic signed [31:0] load_vel_x_i,
  input  logic signed [31:0] load_vel_y_i,
  input  logic signed [31:0] load_vel_z_i,
  input  logic [23:0]        load_inv_mass_i,
  input  logic               load_dynamic_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic               done_o,
  input  logic               applied_o,
  input  logic signed [31:0] first_vel_x_o,
  input  logic signed [31:0] first_vel_y_o,
  input  logic signed [31:0] first_vel_z_o,
  input  logic signed [31:0] second_vel_x_o,
  input  logic signed [31:0] second_vel_y_o,
  input  logic signed [31:0] second_vel_z_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import cir_pkg::*;

  typedef struct {
    logic               applied;
    logic signed [31:0] first_vel[3];
    logic signed [31:0] second_vel[3];
  } body_result_t;

  // shadow copy of the body table
  logic signed [31:0] shadow_vel[BODY_COUNT][3];
  logic [23:0]        shadow_inv[BODY_COUNT];
  logic               shadow_dyn[BODY_COUNT];

  body_result_t expected_results[$];

  function automatic logic signed [31:0] clamp32(longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint signed eff_inv(int b);
    return (shadow_inv[b] == 24'd0) ? 64'sd65536 : longint'(shadow_inv[b]);
  endfunction

  // work out the result of one transfer and update the shadow table
  function automatic body_result_t resolve_item(logic [1:0] fn, int a, int b,
      logic signed [31:0] lv[3], logic [23:0] linv, logic ldyn,
      logic signed [15:0] nrm[3]);
    body_result_t r;
    longint signed va[3], vb[3], dot, ia, ib, ka, kb;
    logic [63:0] num, j, pa, pb;
    logic signed [31:0] na[3], nb[3];
    r.applied = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r.first_vel[i] = '0;
      r.second_vel[i] = '0;
    end
    if (fn == FUNC_LOAD) begin
      for (int i = 0; i < 3; i++) shadow_vel[a][i] = lv[i];
      shadow_inv[a] = linv;
      shadow_dyn[a] = ldyn;
    end
    if (fn == FUNC_CONTACT) begin
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        va[i] = shadow_vel[a][i];
        vb[i] = shadow_vel[b][i];
        dot += (vb[i] - va[i]) * longint'(nrm[i]);
      end
      // approaching bodies only
      if (dot < 0) begin
        ia = eff_inv(a);
        ib = eff_inv(b);
        num = 64'(-dot) * 64'd8;
        j = num / 64'(ia + ib);
        pa = j * 64'(ia);
        pb = j * 64'(ib);
        ka = longint'(pa >> 16);
        kb = longint'(pb >> 16);
        for (int i = 0; i < 3; i++) begin
          na[i] = clamp32(va[i] - ((ka * longint'(nrm[i])) >>> 14));
          nb[i] = clamp32(vb[i] + ((kb * longint'(nrm[i])) >>> 14));
        end
        if (shadow_dyn[a]) for (int i = 0; i < 3; i++) shadow_vel[a][i] = na[i];
        if (shadow_dyn[b]) for (int i = 0; i < 3; i++) shadow_vel[b][i] = nb[i];
        r.applied = 1'b1;
      end
      for (int i = 0; i < 3; i++) r.second_vel[i] = shadow_vel[b][i];
    end
    if (fn == FUNC_LOAD || fn == FUNC_CONTACT || fn == FUNC_READ)
      for (int i = 0; i < 3; i++) r.first_vel[i] = shadow_vel[a][i];
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // compare results first, then record any new transfer
  always @(posedge clk_i) begin
    body_result_t exp_r;
    logic signed [31:0] lv[3];
    logic signed [15:0] nrm[3];
    int errs;
    if (done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no transfer waiting", $time);
        fail_count_o <= fail_count_o + 1;
      end else begin
        exp_r = expected_results.pop_front();
        errs = field_diff("applied", 32'(exp_r.applied), 32'(applied_o));
        errs += field_diff("first_vel_x", exp_r.first_vel[0], first_vel_x_o);
        errs += field_diff("first_vel_y", exp_r.first_vel[1], first_vel_y_o);
        errs += field_diff("first_vel_z", exp_r.first_vel[2], first_vel_z_o);
        errs += field_diff("second_vel_x", exp_r.second_vel[0], second_vel_x_o);
        errs += field_diff("second_vel_y", exp_r.second_vel[1], second_vel_y_o);
        errs += field_diff("second_vel_z", exp_r.second_vel[2], second_vel_z_o);
        if (errs != 0) fail_count_o <= fail_count_o + 1;
      end
    end
    if (rst_ni && start && !busy) begin
      lv[0] = load_vel_x_i;
      lv[1] = load_vel_y_i;
      lv[2] = load_vel_z_i;
      nrm[0] = normal_x_i;
      nrm[1] = normal_y_i;
      nrm[2] = normal_z_i;
      expected_results.push_back(resolve_item(func_i, int'(first_index_i),
          int'(second_index_i), lv, load_inv_mass_i, load_dynamic_i, nrm));
    end
    pending_o <= expected_results.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    for (int b = 0; b < BODY_COUNT; b++) begin
      for (int i = 0; i < 3; i++) shadow_vel[b][i] = '0;
      shadow_inv[b] = '0;
      shadow_dyn[b] = 1'b0;
    end
  end

endmodule

// File: verif/tb_collision_impulse_resolver.sv
module tb_collision_impulse_resolver;

  timeunit 1ns;
  timeprecision 1ps;

  import cir_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func_i = '0;
  logic [5:0]         first_index_i = '0;
  logic [5:0]         second_index_i = '0;
  logic signed [31:0] load_vel_x_i = '0;
  logic signed [31:0] load_vel_y_i = '0;
  logic signed [31:0] load_vel_z_i = '0;
  logic [23:0]        load_inv_mass_i = '0;
  logic               load_dynamic_i = 1'b0;
  logic signed [15:0] normal_x_i = '0;
  logic signed [15:0] normal_y_i = '0;
  logic signed [15:0] normal_z_i = '0;
  logic               done_o;
  logic               applied_o;
  logic signed [31:0] first_vel_x_o, first_vel_y_o, first_vel_z_o;
  logic signed [31:0] second_vel_x_o, second_vel_y_o, second_vel_z_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 idle_pct = 0;
  logic               loaded[BODY_COUNT];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  collision_impulse_resolver dut (.*);

  tb_cir_checker u_checker (
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .*
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one command transfer, with a random gap in front
  task automatic issue(logic [1:0] fn, int a, int b, logic signed [31:0] vx,
      logic signed [31:0] vy, logic signed [31:0] vz, logic [23:0] inv,
      logic dyn, logic signed [15:0] nx, logic signed [15:0] ny,
      logic signed [15:0] nz);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= fn;
    first_index_i <= a[5:0];
    second_index_i <= b[5:0];
    load_vel_x_i <= vx;
    load_vel_y_i <= vy;
    load_vel_z_i <= vz;
    load_inv_mass_i <= inv;
    load_dynamic_i <= dyn;
    normal_x_i <= nx;
    normal_y_i <= ny;
    normal_z_i <= nz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (fn == FUNC_LOAD) loaded[a] = 1'b1;
  endtask

  function automatic logic signed [31:0] pick_vel();
    case ($urandom_range(7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(2097152)) - 1048576);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_normal();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [23:0] pick_inv();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hffffff;
      2: return 24'd65536;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int pick_loaded();
    int b;
    b = $urandom_range(BODY_COUNT - 1);
    while (!loaded[b]) b = $urandom_range(BODY_COUNT - 1);
    return b;
  endfunction

  initial begin
    int a, b, sel;
    for (int i = 0; i < BODY_COUNT; i++) loaded[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every function, the special cases
    issue(FUNC_LOAD, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'd0, 1'b1,
          '0, '0, '0);
    issue(FUNC_LOAD, 1, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hffffff,
          1'b1, '0, '0, '0);
    issue(FUNC_LOAD, 2, 0, 0, 0, 0, 24'd1, 1'b0, '0, '0, '0);
    issue(FUNC_LOAD, 63, 0, 32'sd65536, -32'sd65536, 32'sd0, 24'd65536, 1'b1,
          '0, '0, '0);
    issue(FUNC_CONTACT, 0, 1, 0, 0, 0, 24'd0, 1'b0, 16'sd16384, 16'sd0, 16'sd0);
    issue(FUNC_CONTACT, 1, 0, 0, 0, 0, 24'd0, 1'b0, -16'sd16384, 16'sd0, 16'sd0);
    issue(FUNC_CONTACT, 63, 63, 0, 0, 0, 24'd0, 1'b0, 16'sd16384, 16'sd0, 16'sd0);
    issue(FUNC_CONTACT, 63, 2, 0, 0, 0, 24'd0, 1'b0, 16'sd11585, -16'sd11585, 16'sd0);
    issue(FUNC_CONTACT, 2, 63, 0, 0, 0, 24'd0, 1'b0, 16'sd0, 16'sd16384, 16'sd0);
    issue(FUNC_CONTACT, 63, 0, 0, 0, 0, 24'd0, 1'b0, 16'sd0, 16'sd0, -16'sd16384);
    issue(FUNC_CONTACT, 63, 1, 0, 0, 0, 24'd0, 1'b0, 16'sd9459, 16'sd9459, 16'sd9459);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 24'd0, 1'b0, '0, '0, '0);
    issue(FUNC_READ, 63, 0, 0, 0, 0, 24'd0, 1'b0, '0, '0, '0);
    issue(FUNC_UNUSED, 5, 9, 32'sh7fffffff, 0, 0, 24'hffffff, 1'b1, '0, '0, '0);
    issue(FUNC_READ, 1, 0, 32'sh80000000, 0, 0, 24'd0, 1'b1, -16'sd1, 16'sd1, '0);

    // random: mostly contacts between loaded bodies, fresh loads, reads and unused codes mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) idle_pct = 70;
      else if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      else if (n == 0) idle_pct = 31;
      if (n < 200 && n % 40 >= 35) idle_pct = 0;
      else if (n < 200) idle_pct = 31;
      sel = $urandom_range(99);
      if (sel < 25) begin
        issue(FUNC_LOAD, $urandom_range(BODY_COUNT - 1), $urandom_range(BODY_COUNT - 1),
              pick_vel(), pick_vel(), pick_vel(), pick_inv(), 1'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 85) begin
        a = pick_loaded();
        b = ($urandom_range(19) == 0) ? a : pick_loaded();
        issue(FUNC_CONTACT, a, b, $urandom, $urandom, $urandom, 24'($urandom),
              1'($urandom), pick_normal(), pick_normal(), pick_normal());
      end else if (sel < 95) begin
        issue(FUNC_READ, pick_loaded(), $urandom_range(BODY_COUNT - 1), $urandom,
              $urandom, $urandom, 24'($urandom), 1'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
      end else begin
        issue(FUNC_UNUSED, $urandom_range(BODY_COUNT - 1), $urandom_range(BODY_COUNT - 1),
              $urandom, $urandom, $urandom, 24'($urandom), 1'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
      end
    end

    // drain, then let the longest contact settle
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cir_pkg.sv
rtl/cir_ctrl.sv
rtl/cir_datapath.sv
rtl/collision_impulse_resolver.sv
rtl/cir_checker.sv
verif/cir_checker.sv
verif/tb_collision_impulse_resolver.sv
